FILE: rtl/cse_pkg.sv
// Shared constants, codes and item types of the cubic spline evaluator.
// Used by every module of the block but cse_ram; depends on nothing else.
`timescale 1ns / 1ps

package cse_pkg;

  localparam int unsigned MAX_KNOTS = 64;
  localparam int unsigned IDX_W     = $clog2(MAX_KNOTS);
  localparam int unsigned FRAC_BITS = 16;
  localparam int unsigned DATA_W    = 32;
  localparam int unsigned H_W       = DATA_W + 1;
  localparam int unsigned ACC_W     = 64;
  // Room for six times a data word.
  localparam int unsigned COEF_W    = DATA_W + 3;
  localparam int unsigned MUL_CHUNK = 11;
  localparam int unsigned MUL_STEPS = (H_W + MUL_CHUNK - 1) / MUL_CHUNK;
  localparam int unsigned UB_W      = MUL_STEPS * MUL_CHUNK;
  localparam int unsigned MCNT_W    = (MUL_STEPS > 1) ? $clog2(MUL_STEPS) : 1;
  localparam int unsigned PROD_W    = ACC_W + UB_W;
  localparam int unsigned Q_W       = PROD_W - FRAC_BITS;
  localparam int unsigned KC_W      = 7;
  localparam int unsigned ORD_W     = 3;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned FIFO_DEPTH = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_KNOT_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LEFT_CURV  = 2'd1;

  localparam logic ACT_LOAD  = 1'b0;
  localparam logic ACT_QUERY = 1'b1;

  localparam logic [1:0] REGION_BELOW  = 2'd0;
  localparam logic [1:0] REGION_INSIDE = 2'd1;
  localparam logic [1:0] REGION_ABOVE  = 2'd2;

  localparam logic [ORD_W-1:0] ORD_VALUE  = 3'd0;
  localparam logic [ORD_W-1:0] ORD_FIRST  = 3'd1;
  localparam logic [ORD_W-1:0] ORD_SECOND = 3'd2;
  localparam logic [ORD_W-1:0] ORD_THIRD  = 3'd3;

  localparam logic [ACC_W-1:0] S64_MAX = {1'b0, {(ACC_W-1){1'b1}}};
  localparam logic [ACC_W-1:0] S64_MIN = {1'b1, {(ACC_W-1){1'b0}}};

  typedef struct packed {
    logic                     action;
    logic [IDX_W-1:0]         entry_index;
    logic signed [DATA_W-1:0] knot_pos;
    logic signed [DATA_W-1:0] knot_value;
    logic signed [DATA_W-1:0] slope_coef;
    logic signed [DATA_W-1:0] curve_coef;
    logic signed [DATA_W-1:0] cubic_coef;
    logic signed [DATA_W-1:0] query_pos;
    logic [ORD_W-1:0]         deriv_order;
  } in_item_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] result_value;
    logic [IDX_W-1:0]         segment;
    logic [1:0]               region;
    logic                     saturated;
  } out_item_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] value;
    logic signed [DATA_W-1:0] slope;
    logic signed [DATA_W-1:0] curve;
    logic signed [DATA_W-1:0] cubic;
  } coef_t;

  typedef struct packed {
    logic                  is_load;
    logic [IDX_W-1:0]      index;
    logic [1:0]            region;
    logic [ORD_W-1:0]      order;
    logic signed [H_W-1:0] h;
    coef_t                 coef;
  } q_entry_t;

endpackage

FILE: rtl/cse_ram.sv
// Generic simple dual-port RAM with one write port and one registered read port.
// Self-contained; used for the knot position and coefficient tables.
`timescale 1ns / 1ps

module cse_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64,
  localparam int unsigned AW = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

FILE: rtl/cse_front.sv
// Front end: accepts items, writes knot positions and scans for the segment.
// Depends on cse_pkg and cse_ram; hands classified items to the queue.
`timescale 1ns / 1ps

module cse_front (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           push_i,
  output logic                           full_o,
  input  cse_pkg::in_item_t              item_i,
  input  logic [cse_pkg::IDX_W-1:0]      n_last_i,
  output logic                           q_push_o,
  input  logic                           q_full_i,
  output cse_pkg::q_entry_t              q_entry_o
);

  typedef enum logic [6:0] {
    F_IDLE = 7'b0000001,
    F_RD0  = 7'b0000010,
    F_RDN  = 7'b0000100,
    F_CHK  = 7'b0001000,
    F_MID  = 7'b0010000,
    F_CMP  = 7'b0100000,
    F_PUSH = 7'b1000000
  } front_state_e;

  front_state_e state_q, state_d;

  logic                              kind_q, kind_d;
  logic [cse_pkg::IDX_W-1:0]         lo_q, lo_d, hi_q, hi_d;
  logic signed [cse_pkg::DATA_W-1:0] x_q, x_d, p0_q, p0_d, pbase_q, pbase_d;
  logic [cse_pkg::ORD_W-1:0]         order_q, order_d;
  logic [1:0]                        region_q, region_d;
  cse_pkg::coef_t                    coef_q, coef_d;

  logic                              pos_we;
  logic [cse_pkg::IDX_W-1:0]         pos_raddr;
  logic [cse_pkg::DATA_W-1:0]        pos_rdata;
  logic signed [cse_pkg::DATA_W-1:0] pos_s;

  assign pos_s   = pos_rdata;
  assign pos_we  = state_q == F_IDLE && push_i && item_i.action == cse_pkg::ACT_LOAD;
  assign full_o  = state_q != F_IDLE;

  // The scan reads one address ahead, so each cycle in F_CMP checks one knot.
  always_comb begin
    case (state_q)
      F_RD0:   pos_raddr = '0;
      F_RDN:   pos_raddr = n_last_i;
      F_MID:   pos_raddr = hi_q;
      F_CMP:   pos_raddr = hi_q - 1'b1;
      default: pos_raddr = '0;
    endcase
  end

  cse_ram #(
    .WIDTH(cse_pkg::DATA_W),
    .DEPTH(cse_pkg::MAX_KNOTS)
  ) u_pos_ram (
    .clk_i  (clk_i),
    .we_i   (pos_we),
    .waddr_i(item_i.entry_index),
    .wdata_i(item_i.knot_pos),
    .raddr_i(pos_raddr),
    .rdata_o(pos_rdata)
  );

  always_comb begin
    state_d  = state_q;
    kind_d   = kind_q;
    lo_d     = lo_q;
    hi_d     = hi_q;
    x_d      = x_q;
    p0_d     = p0_q;
    pbase_d  = pbase_q;
    order_d  = order_q;
    region_d = region_q;
    coef_d   = coef_q;
    q_push_o = 1'b0;
    case (state_q)
      F_IDLE: begin
        if (push_i) begin
          kind_d   = item_i.action;
          x_d      = item_i.query_pos;
          order_d  = item_i.deriv_order;
          hi_d     = n_last_i;
          coef_d   = '{value: item_i.knot_value, slope: item_i.slope_coef,
                       curve: item_i.curve_coef, cubic: item_i.cubic_coef};
          region_d = cse_pkg::REGION_INSIDE;
          if (item_i.action == cse_pkg::ACT_LOAD) begin
            lo_d    = item_i.entry_index;
            state_d = F_PUSH;
          end else begin
            lo_d    = '0;
            state_d = F_RD0;
          end
        end
      end
      F_RD0: begin
        state_d = F_RDN;
      end
      F_RDN: begin
        p0_d    = pos_s;
        state_d = F_CHK;
      end
      F_CHK: begin
        if (x_q < p0_q) begin
          region_d = cse_pkg::REGION_BELOW;
          lo_d     = '0;
          pbase_d  = p0_q;
          state_d  = F_PUSH;
        end else if (x_q > pos_s) begin
          region_d = cse_pkg::REGION_ABOVE;
          lo_d     = hi_q;
          pbase_d  = pos_s;
          state_d  = F_PUSH;
        end else if (x_q == pos_s) begin
          lo_d    = hi_q;
          pbase_d = pos_s;
          state_d = F_PUSH;
        end else begin
          // Walk down from the next-to-last knot; the first knot is at or
          // below x here, so the walk always stops by entry zero.
          hi_d    = hi_q - 1'b1;
          state_d = F_MID;
        end
      end
      F_MID: begin
        state_d = F_CMP;
      end
      F_CMP: begin
        if (pos_s <= x_q) begin
          lo_d    = hi_q;
          pbase_d = pos_s;
          state_d = F_PUSH;
        end else begin
          hi_d = hi_q - 1'b1;
        end
      end
      F_PUSH: begin
        if (!q_full_i) begin
          q_push_o = 1'b1;
          state_d  = F_IDLE;
        end
      end
      default: begin
        state_d = F_IDLE;
      end
    endcase
  end

  always_comb begin
    q_entry_o.is_load = kind_q == cse_pkg::ACT_LOAD;
    q_entry_o.index   = lo_q;
    q_entry_o.region  = region_q;
    q_entry_o.order   = order_q;
    q_entry_o.h       = {x_q[cse_pkg::DATA_W-1], x_q} - {pbase_q[cse_pkg::DATA_W-1], pbase_q};
    q_entry_o.coef    = coef_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q   <= kind_d;
    lo_q     <= lo_d;
    hi_q     <= hi_d;
    x_q      <= x_d;
    p0_q     <= p0_d;
    pbase_q  <= pbase_d;
    order_q  <= order_d;
    region_q <= region_d;
    coef_q   <= coef_d;
  end

`ifndef SYNTHESIS
  a_scan_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == F_MID || state_q == F_CMP) |-> hi_q < n_last_i)
    else $error("knot scan started at or above the last knot");
  a_below_seg0: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_push_o && !q_entry_o.is_load && q_entry_o.region == cse_pkg::REGION_BELOW
      |-> q_entry_o.index == '0)
    else $error("query below the first knot must use segment zero");
`endif

endmodule

FILE: rtl/cse_fifo.sv
// Short queue of classified items between the front end and the evaluator.
// Depends on cse_pkg for the entry type and depth.
`timescale 1ns / 1ps

module cse_fifo (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  output logic              full_o,
  input  cse_pkg::q_entry_t data_i,
  input  logic              pop_i,
  output logic              empty_o,
  output cse_pkg::q_entry_t data_o
);

  localparam int unsigned PTR_W = (cse_pkg::FIFO_DEPTH > 1) ? $clog2(cse_pkg::FIFO_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(cse_pkg::FIFO_DEPTH + 1);

  cse_pkg::q_entry_t mem_q [cse_pkg::FIFO_DEPTH];
  logic [PTR_W-1:0]  wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0]  count_q;
  logic              do_push, do_pop;

  assign full_o  = count_q == CNT_W'(cse_pkg::FIFO_DEPTH);
  assign empty_o = count_q == '0;
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PTR_W'(cse_pkg::FIFO_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PTR_W'(cse_pkg::FIFO_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

FILE: rtl/cse_back.sv
// Evaluator: coefficient table, Horner sequencer with an iterative multiplier.
// Depends on cse_pkg and cse_ram; drains the queue and holds one result.
`timescale 1ns / 1ps

module cse_back (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              q_empty_i,
  output logic                              q_pop_o,
  input  cse_pkg::q_entry_t                 q_entry_i,
  input  logic signed [cse_pkg::DATA_W-1:0] left_curv_i,
  input  logic                              pop_i,
  output logic                              empty_o,
  output cse_pkg::out_item_t                result_o
);

  localparam int unsigned AW = cse_pkg::ACC_W;
  localparam int unsigned CW = cse_pkg::COEF_W;
  localparam int unsigned DW = cse_pkg::DATA_W;

  typedef enum logic [6:0] {
    B_IDLE  = 7'b0000001,
    B_FETCH = 7'b0000010,
    B_PREP  = 7'b0000100,
    B_MUL   = 7'b0001000,
    B_NORM  = 7'b0010000,
    B_ADD   = 7'b0100000,
    B_DONE  = 7'b1000000
  } back_state_e;

  back_state_e state_q, state_d;

  logic [cse_pkg::IDX_W-1:0]    seg_q, seg_d;
  logic [1:0]                   region_q, region_d;
  logic [cse_pkg::ORD_W-1:0]    order_q, order_d;
  logic                         h_neg_q, h_neg_d;
  logic [cse_pkg::UB_W-1:0]     hmag_q, hmag_d;
  logic [AW-1:0]                r_q, r_d;
  logic [CW-1:0]                add0_q, add0_d, add1_q, add1_d, add2_q, add2_d;
  logic [1:0]                   steps_q, steps_d;
  logic [AW-1:0]                ua_q, ua_d;
  logic [cse_pkg::UB_W-1:0]     ub_q, ub_d;
  logic                         neg_q, neg_d;
  logic [cse_pkg::PROD_W-1:0]   acc_q, acc_d;
  logic [cse_pkg::MCNT_W-1:0]   mcnt_q, mcnt_d;
  logic [AW-1:0]                prod_q, prod_d;
  logic                         sat_q, sat_d;
  cse_pkg::out_item_t           res_q, res_d;
  logic                         res_valid_q, res_valid_d;

  logic [$bits(cse_pkg::coef_t)-1:0] coef_rdata;
  cse_pkg::coef_t                    rd;
  logic                              coef_we;

  logic [CW-1:0]   y35, b35, c35, d35, d3, d6, c2, oc35, oc2;
  logic [AW-1:0]   r_init;
  logic [CW-1:0]   a0_init, a1_init, a2_init;
  logic [1:0]      n_init;
  logic [cse_pkg::PROD_W-1:0] partial;
  logic [cse_pkg::Q_W-1:0]    qmag;
  logic            norm_ovf;
  logic [AW-1:0]   norm_val;
  logic [AW:0]     sum;
  logic            add_ovf;
  logic [AW-1:0]   add_val;
  logic            fits32;
  logic [DW-1:0]   clip_val;
  logic            can_emit;

  assign q_pop_o = state_q == B_IDLE && !q_empty_i;
  assign coef_we = q_pop_o && q_entry_i.is_load;
  assign rd      = coef_rdata;
  assign empty_o = !res_valid_q;
  assign result_o = res_q;

  cse_ram #(
    .WIDTH($bits(cse_pkg::coef_t)),
    .DEPTH(cse_pkg::MAX_KNOTS)
  ) u_coef_ram (
    .clk_i  (clk_i),
    .we_i   (coef_we),
    .waddr_i(q_entry_i.index),
    .wdata_i(q_entry_i.coef),
    .raddr_i(q_entry_i.index),
    .rdata_o(coef_rdata)
  );

  // Coefficients, the curvature for the query's region, and exact multiples by two, three and six.
  always_comb begin
    y35  = {{(CW-DW){rd.value[DW-1]}}, rd.value};
    b35  = {{(CW-DW){rd.slope[DW-1]}}, rd.slope};
    c35  = {{(CW-DW){rd.curve[DW-1]}}, rd.curve};
    d35  = {{(CW-DW){rd.cubic[DW-1]}}, rd.cubic};
    d3   = {d35[CW-2:0], 1'b0} + d35;
    d6   = {d3[CW-2:0], 1'b0};
    c2   = {c35[CW-2:0], 1'b0};
    oc35 = (region_q == cse_pkg::REGION_BELOW) ?
           {{(CW-DW){left_curv_i[DW-1]}}, left_curv_i} : c35;
    oc2  = {oc35[CW-2:0], 1'b0};
  end

  // Start value and the addends of each Horner step, by region and order.
  always_comb begin
    r_init  = '0;
    a0_init = '0;
    a1_init = '0;
    a2_init = '0;
    n_init  = 2'd0;
    if (region_q == cse_pkg::REGION_INSIDE) begin
      case (order_q)
        cse_pkg::ORD_VALUE: begin
          r_init  = {{(AW-CW){d35[CW-1]}}, d35};
          a0_init = c35;
          a1_init = b35;
          a2_init = y35;
          n_init  = 2'd3;
        end
        cse_pkg::ORD_FIRST: begin
          r_init  = {{(AW-CW){d3[CW-1]}}, d3};
          a0_init = c2;
          a1_init = b35;
          n_init  = 2'd2;
        end
        cse_pkg::ORD_SECOND: begin
          r_init  = {{(AW-CW){d6[CW-1]}}, d6};
          a0_init = c2;
          n_init  = 2'd1;
        end
        cse_pkg::ORD_THIRD: begin
          r_init  = {{(AW-CW){d6[CW-1]}}, d6};
        end
        default: ;
      endcase
    end else begin
      case (order_q)
        cse_pkg::ORD_VALUE: begin
          r_init  = {{(AW-CW){oc35[CW-1]}}, oc35};
          a0_init = b35;
          a1_init = y35;
          n_init  = 2'd2;
        end
        cse_pkg::ORD_FIRST: begin
          r_init  = {{(AW-CW){oc2[CW-1]}}, oc2};
          a0_init = b35;
          n_init  = 2'd1;
        end
        cse_pkg::ORD_SECOND: begin
          r_init  = {{(AW-CW){oc2[CW-1]}}, oc2};
        end
        default: ;
      endcase
    end
  end

  // One chunk of the magnitude product, most significant chunk first.
  assign partial = {{(cse_pkg::PROD_W-AW){1'b0}}, ua_q} *
                   {{(cse_pkg::PROD_W-cse_pkg::MUL_CHUNK){1'b0}},
                    ub_q[cse_pkg::UB_W-1 -: cse_pkg::MUL_CHUNK]};

  // Drop the fraction rounding toward minus infinity, then saturate.
  always_comb begin
    qmag = acc_q[cse_pkg::PROD_W-1:cse_pkg::FRAC_BITS] +
           cse_pkg::Q_W'(neg_q && (acc_q[cse_pkg::FRAC_BITS-1:0] != '0));
    if (!neg_q) begin
      norm_ovf = qmag[cse_pkg::Q_W-1:AW-1] != '0;
      norm_val = norm_ovf ? cse_pkg::S64_MAX : qmag[AW-1:0];
    end else begin
      norm_ovf = (qmag[cse_pkg::Q_W-1:AW] != '0) ||
                 (qmag[AW-1] && (qmag[AW-2:0] != '0));
      norm_val = norm_ovf ? cse_pkg::S64_MIN : (~qmag[AW-1:0] + 1'b1);
    end
  end

  always_comb begin
    sum     = {prod_q[AW-1], prod_q} + {{(AW+1-CW){add0_q[CW-1]}}, add0_q};
    add_ovf = sum[AW] != sum[AW-1];
    add_val = add_ovf ? (sum[AW] ? cse_pkg::S64_MIN : cse_pkg::S64_MAX) : sum[AW-1:0];
  end

  always_comb begin
    fits32   = (&r_q[AW-1:DW-1]) || !(|r_q[AW-1:DW-1]);
    clip_val = fits32 ? r_q[DW-1:0] : (r_q[AW-1] ? {1'b1, {(DW-1){1'b0}}}
                                                  : {1'b0, {(DW-1){1'b1}}});
  end

  assign can_emit = !res_valid_q || pop_i;

  always_comb begin
    state_d     = state_q;
    seg_d       = seg_q;
    region_d    = region_q;
    order_d     = order_q;
    h_neg_d     = h_neg_q;
    hmag_d      = hmag_q;
    r_d         = r_q;
    add0_d      = add0_q;
    add1_d      = add1_q;
    add2_d      = add2_q;
    steps_d     = steps_q;
    ua_d        = ua_q;
    ub_d        = ub_q;
    neg_d       = neg_q;
    acc_d       = acc_q;
    mcnt_d      = mcnt_q;
    prod_d      = prod_q;
    sat_d       = sat_q;
    res_d       = res_q;
    res_valid_d = res_valid_q && !pop_i;
    case (state_q)
      B_IDLE: begin
        if (q_pop_o && !q_entry_i.is_load) begin
          seg_d    = q_entry_i.index;
          region_d = q_entry_i.region;
          order_d  = q_entry_i.order;
          h_neg_d  = q_entry_i.h[cse_pkg::H_W-1];
          hmag_d   = cse_pkg::UB_W'(q_entry_i.h[cse_pkg::H_W-1] ?
                                    -q_entry_i.h : q_entry_i.h);
          state_d  = B_FETCH;
        end
      end
      B_FETCH: begin
        r_d     = r_init;
        add0_d  = a0_init;
        add1_d  = a1_init;
        add2_d  = a2_init;
        steps_d = n_init;
        sat_d   = 1'b0;
        state_d = (n_init != 2'd0) ? B_PREP : B_DONE;
      end
      B_PREP: begin
        ua_d    = r_q[AW-1] ? (~r_q + 1'b1) : r_q;
        ub_d    = hmag_q;
        neg_d   = r_q[AW-1] ^ h_neg_q;
        acc_d   = '0;
        mcnt_d  = '0;
        state_d = B_MUL;
      end
      B_MUL: begin
        acc_d = {acc_q[cse_pkg::PROD_W-1-cse_pkg::MUL_CHUNK:0],
                 {cse_pkg::MUL_CHUNK{1'b0}}} + partial;
        ub_d  = {ub_q[cse_pkg::UB_W-1-cse_pkg::MUL_CHUNK:0], {cse_pkg::MUL_CHUNK{1'b0}}};
        if (mcnt_q == cse_pkg::MCNT_W'(cse_pkg::MUL_STEPS - 1)) begin
          mcnt_d  = '0;
          state_d = B_NORM;
        end else begin
          mcnt_d = mcnt_q + 1'b1;
        end
      end
      B_NORM: begin
        prod_d  = norm_val;
        sat_d   = sat_q || norm_ovf;
        state_d = B_ADD;
      end
      B_ADD: begin
        r_d     = add_val;
        sat_d   = sat_q || add_ovf;
        add0_d  = add1_q;
        add1_d  = add2_q;
        steps_d = steps_q - 1'b1;
        state_d = (steps_q == 2'd1) ? B_DONE : B_PREP;
      end
      B_DONE: begin
        if (can_emit) begin
          res_d.result_value = clip_val;
          res_d.segment      = seg_q;
          res_d.region       = region_q;
          res_d.saturated    = sat_q || !fits32;
          res_valid_d        = 1'b1;
          state_d            = B_IDLE;
        end
      end
      default: begin
        state_d = B_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_IDLE;
      res_valid_q <= 1'b0;
      mcnt_q      <= '0;
      steps_q     <= 2'd0;
    end else begin
      state_q     <= state_d;
      res_valid_q <= res_valid_d;
      mcnt_q      <= mcnt_d;
      steps_q     <= steps_d;
    end
  end

  always_ff @(posedge clk_i) begin
    seg_q    <= seg_d;
    region_q <= region_d;
    order_q  <= order_d;
    h_neg_q  <= h_neg_d;
    hmag_q   <= hmag_d;
    r_q      <= r_d;
    add0_q   <= add0_d;
    add1_q   <= add1_d;
    add2_q   <= add2_d;
    ua_q     <= ua_d;
    ub_q     <= ub_d;
    neg_q    <= neg_d;
    acc_q    <= acc_d;
    prod_q   <= prod_d;
    sat_q    <= sat_d;
    res_q    <= res_d;
  end

`ifndef SYNTHESIS
  a_prep_has_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == B_PREP |-> steps_q != 2'd0)
    else $error("Horner step started with no step left");
  a_mcnt_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != B_MUL |-> mcnt_q == '0)
    else $error("multiplier chunk counter left running");
  a_result_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_q && !pop_i |=> res_valid_q && $stable(res_q))
    else $error("waiting result lost or overwritten");
`endif

endmodule

FILE: rtl/cubic_spline_evaluator.sv
// Top level of the piecewise cubic spline evaluator.
// Depends on cse_pkg, cse_front, cse_fifo and cse_back.
`timescale 1ns / 1ps

// The block evaluates a piecewise cubic spline in signed Q16.16. A load item
// (action 0) writes one knot entry, which passes through the front end and
// a queue slot; it produces no result. A query item (action 1) finds the
// last knot at or below query_pos by scanning the knot position RAM downward
// and returns one result: the value or the first, second or third derivative,
// extrapolated quadratically outside the knots, with a sticky saturation flag.
// The front end reads the first and last knot positions and classifies the
// query in F_RD0, F_RDN and F_CHK. A query outside the knots or exactly on the
// last knot goes straight to the queue; any other query starts the scan in
// F_MID and then checks one knot per cycle in F_CMP, from the next-to-last
// knot down to the segment found, so up to 63 checks for 64 knots. The entry
// then waits in F_PUSH while the queue is full, and the front end takes the
// next item only once it is back in F_IDLE. Per Horner step the evaluator
// runs a setup, three 64-by-11 partial products of the iterative multiplier,
// a rounding step and a saturating add, between fetching the coefficients
// and emitting the result; a third derivative or an unsupported order needs
// no Horner step. A two-entry queue lets the front end work on the next item
// while the current one is evaluated, so the front end can take a new item
// before the evaluator is through with the last one. Results wait in a
// one-entry output register while the next item is already being worked on.
// The configuration registers knot_count (index 0) and left_curvature
// (index 1) may be written only while the block is idle; knot_count is
// clamped to the range 3 to 64. Every knot below the clamped count must be
// loaded before it is queried; the positions need not be sorted, the scan
// always picks the highest such knot at or below the query.

module cubic_spline_evaluator (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              push,
  output logic                              full,
  input  cse_pkg::in_item_t                 item_i,
  output logic                              empty,
  input  logic                              pop,
  output cse_pkg::out_item_t                result_o,
  input  logic                              valid,
  output logic                              ready,
  input  logic [cse_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [cse_pkg::DATA_W-1:0]        cfg_data_i
);

  logic [cse_pkg::KC_W-1:0]          knot_count_q;
  logic signed [cse_pkg::DATA_W-1:0] left_curv_q;
  logic [cse_pkg::IDX_W-1:0]         n_last;

  logic              q_push, q_full, q_pop, q_empty;
  cse_pkg::q_entry_t q_in, q_out;

  // Configuration writes are always taken.
  assign ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      knot_count_q <= cse_pkg::KC_W'(3);
      left_curv_q  <= '0;
    end else if (valid && ready) begin
      if (cfg_index_i == cse_pkg::CFG_KNOT_COUNT) begin
        knot_count_q <= cfg_data_i[cse_pkg::KC_W-1:0];
      end else if (cfg_index_i == cse_pkg::CFG_LEFT_CURV) begin
        left_curv_q <= cfg_data_i;
      end
    end
  end

  // Index of the last valid knot, after clamping the count to its legal range.
  always_comb begin
    if (knot_count_q < cse_pkg::KC_W'(3)) begin
      n_last = cse_pkg::IDX_W'(2);
    end else if (knot_count_q > cse_pkg::KC_W'(cse_pkg::MAX_KNOTS)) begin
      n_last = cse_pkg::IDX_W'(cse_pkg::MAX_KNOTS - 1);
    end else begin
      n_last = cse_pkg::IDX_W'(knot_count_q - 1'b1);
    end
  end

  cse_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .full_o   (full),
    .item_i   (item_i),
    .n_last_i (n_last),
    .q_push_o (q_push),
    .q_full_i (q_full),
    .q_entry_o(q_in)
  );

  cse_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (q_push),
    .full_o (q_full),
    .data_i (q_in),
    .pop_i  (q_pop),
    .empty_o(q_empty),
    .data_o (q_out)
  );

  cse_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_empty_i  (q_empty),
    .q_pop_o    (q_pop),
    .q_entry_i  (q_out),
    .left_curv_i(left_curv_q),
    .pop_i      (pop),
    .empty_o    (empty),
    .result_o   (result_o)
  );

endmodule

FILE: tb/cubic_spline_evaluator_tb.sv
// Self-checking testbench for the cubic spline evaluator: loads knot tables,
// runs queries under several register settings and random handshake gaps.
// Depends on cse_pkg and the cubic_spline_evaluator top level only.
`timescale 1ns / 1ps

module cubic_spline_evaluator_tb;
  import cse_pkg::*;

  typedef logic signed [63:0]  s64_t;
  typedef logic signed [127:0] s128_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  // Item side and result side of the block, plus the register write channel.
  logic                  push  = 1'b0;
  logic                  full;
  in_item_t              item_i = '0;
  logic                  empty;
  logic                  pop   = 1'b0;
  out_item_t             result_o;
  logic                  valid = 1'b0;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  cfg_index_i = CFG_KNOT_COUNT;
  logic [DATA_W-1:0]     cfg_data_i  = '0;

  cubic_spline_evaluator dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .item_i      (item_i),
    .empty       (empty),
    .pop         (pop),
    .result_o    (result_o),
    .valid       (valid),
    .ready       (ready),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  // Items waiting to be offered, and results that the predictor has worked
  // out but that the block has not yet returned.
  in_item_t  pending_items[$];
  out_item_t expected_results[$];
  int        errors = 0;

  // Idle percentages for the item side and the result side.
  int send_idle = 0;
  int recv_idle = 0;

  // Register shadow, shared by the predictor and the stimulus generator.
  // Both only change while the block is idle.
  logic [KC_W-1:0]          knot_count_reg = 7'd3;
  logic signed [DATA_W-1:0] left_curv_reg  = '0;

  // Knot table as the block holds it, updated when a load item is accepted.
  logic signed [DATA_W-1:0] pos_tab[MAX_KNOTS];
  logic signed [DATA_W-1:0] value_tab[MAX_KNOTS];
  logic signed [DATA_W-1:0] slope_tab[MAX_KNOTS];
  logic signed [DATA_W-1:0] curve_tab[MAX_KNOTS];
  logic signed [DATA_W-1:0] cubic_tab[MAX_KNOTS];

  // Knot positions as they will be once every queued item is accepted. The
  // generator uses this to keep positions increasing and to aim queries.
  logic signed [DATA_W-1:0] planned_pos[MAX_KNOTS];

  // Set by any clipped intermediate while one query is being predicted.
  bit clip_seen;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------
  // Fixed point helpers. Every intermediate is a signed 64-bit value that
  // saturates; clip_seen records that saturation happened anywhere.
  // ---------------------------------------------------------------------
  function automatic s64_t clip64(s128_t v);
    if (v[127:63] != {65{v[127]}}) begin
      clip_seen = 1'b1;
      return v[127] ? s64_t'(S64_MIN) : s64_t'(S64_MAX);
    end
    return v[63:0];
  endfunction

  function automatic s64_t add_sat(s64_t a, s64_t b);
    s128_t s;
    s = s128_t'(a) + s128_t'(b);
    return clip64(s);
  endfunction

  // Exact product, floored by the fraction width, then saturated.
  function automatic s64_t mul_fix(s64_t a, s64_t b);
    s128_t p;
    p = s128_t'(a) * s128_t'(b);
    return clip64(p >>> FRAC_BITS);
  endfunction

  function automatic s64_t scale_sat(s64_t a, int k);
    s128_t p;
    p = s128_t'(a) * s128_t'(k);
    return clip64(p);
  endfunction

  // Works out the one result of a query from the current table and registers.
  function automatic out_item_t spline_query(in_item_t it);
    out_item_t res;
    int        n;
    int        idx;
    s64_t      x;
    s64_t      h;
    s64_t      c2;
    s64_t      r;
    s64_t      d;
    s64_t      c;
    n = (knot_count_reg < 3) ? 3 : (knot_count_reg > MAX_KNOTS) ? MAX_KNOTS : knot_count_reg;
    x = it.query_pos;
    clip_seen = 1'b0;
    r = '0;
    idx = 0;
    // Last knot at or below x, scanning the whole valid range so that an
    // unsorted table gives the same answer as the definition.
    for (int i = 0; i < n; i++) begin
      if (s64_t'(pos_tab[i]) <= x) idx = i;
    end
    if (x < s64_t'(pos_tab[0])) begin
      // Left of the first knot: quadratic with the configured curvature.
      h = x - s64_t'(pos_tab[0]);
      c2 = scale_sat(left_curv_reg, 2);
      res.region = REGION_BELOW;
      res.segment = '0;
      case (it.deriv_order)
        ORD_VALUE: r = add_sat(mul_fix(add_sat(mul_fix(left_curv_reg, h), slope_tab[0]), h),
                               value_tab[0]);
        ORD_FIRST: r = add_sat(mul_fix(c2, h), slope_tab[0]);
        ORD_SECOND: r = c2;
        default: r = '0;
      endcase
    end else if (x > s64_t'(pos_tab[n-1])) begin
      // Right of the last knot: quadratic with that knot's b and c.
      h = x - s64_t'(pos_tab[n-1]);
      c2 = scale_sat(curve_tab[n-1], 2);
      res.region = REGION_ABOVE;
      res.segment = IDX_W'(n - 1);
      case (it.deriv_order)
        ORD_VALUE: r = add_sat(mul_fix(add_sat(mul_fix(curve_tab[n-1], h), slope_tab[n-1]), h),
                               value_tab[n-1]);
        ORD_FIRST: r = add_sat(mul_fix(c2, h), slope_tab[n-1]);
        ORD_SECOND: r = c2;
        default: r = '0;
      endcase
    end else begin
      h = x - s64_t'(pos_tab[idx]);
      d = cubic_tab[idx];
      c = curve_tab[idx];
      res.region = REGION_INSIDE;
      res.segment = IDX_W'(idx);
      case (it.deriv_order)
        ORD_VALUE: begin
          r = add_sat(mul_fix(d, h), c);
          r = add_sat(mul_fix(r, h), slope_tab[idx]);
          r = add_sat(mul_fix(r, h), value_tab[idx]);
        end
        ORD_FIRST: begin
          r = add_sat(mul_fix(scale_sat(d, 3), h), scale_sat(c, 2));
          r = add_sat(mul_fix(r, h), slope_tab[idx]);
        end
        ORD_SECOND: r = add_sat(mul_fix(scale_sat(d, 6), h), scale_sat(c, 2));
        ORD_THIRD: r = scale_sat(d, 6);
        default: r = '0;
      endcase
    end
    // Final clip to the 32-bit result word.
    if (r > 64'sh7FFF_FFFF) begin
      r = 64'sh7FFF_FFFF;
      clip_seen = 1'b1;
    end else if (r < -64'sh8000_0000) begin
      r = -64'sh8000_0000;
      clip_seen = 1'b1;
    end
    res.result_value = r[31:0];
    res.saturated = clip_seen;
    return res;
  endfunction

  // ---------------------------------------------------------------------
  // Item driver. At each edge it first retires an item the block took, then
  // decides whether to offer the next one. An offered item that the block
  // refused stays on the port unchanged.
  // ---------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      push   <= 1'b0;
      item_i <= '0;
    end else if (!(push && full)) begin
      if (push) begin
        if (item_i.action == ACT_LOAD) begin
          pos_tab[item_i.entry_index]   = item_i.knot_pos;
          value_tab[item_i.entry_index] = item_i.knot_value;
          slope_tab[item_i.entry_index] = item_i.slope_coef;
          curve_tab[item_i.entry_index] = item_i.curve_coef;
          cubic_tab[item_i.entry_index] = item_i.cubic_coef;
        end else begin
          expected_results = {expected_results, spline_query(item_i)};
        end
        void'(pending_items.pop_front());
      end
      if (pending_items.size() > 0 && $urandom_range(99) >= send_idle) begin
        push   <= 1'b1;
        item_i <= pending_items[0];
      end else begin
        push <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Result monitor. A result taken at this edge is checked against the
  // oldest expectation, field by field.
  // ---------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        if (expected_results.size() == 0) begin
          errors++;
          $display("%0t: unexpected result: expected none, got %p", $time, result_o);
        end else begin
          if (result_o.result_value !== expected_results[0].result_value ||
              result_o.segment !== expected_results[0].segment ||
              result_o.region !== expected_results[0].region ||
              result_o.saturated !== expected_results[0].saturated) begin
            errors++;
            $display("%0t: result mismatch: expected %p, got %p",
                     $time, expected_results[0], result_o);
          end
          void'(expected_results.pop_front());
        end
      end
      pop <= ($urandom_range(99) >= recv_idle);
    end
  end

  // ---------------------------------------------------------------------
  // Stimulus helpers.
  // ---------------------------------------------------------------------

  // Coefficients mix small, medium, extreme and fully random words so that
  // both clean and saturating arithmetic get exercised.
  function automatic logic [31:0] pick_word();
    case ($urandom_range(4))
      0: return 32'($signed($urandom_range(131071)) - 65536);
      1: return 32'($signed($urandom_range(2097151)) - 1048576);
      2: begin
        case ($urandom_range(3))
          0: return 32'h8000_0000;
          1: return 32'h7FFF_FFFF;
          2: return 32'h0;
          default: return 32'hFFFF_FFFF;
        endcase
      end
      default: return $urandom;
    endcase
  endfunction

  function automatic void queue_load(int e, logic signed [31:0] p);
    in_item_t it;
    it.action      = ACT_LOAD;
    it.entry_index = IDX_W'(e);
    it.knot_pos    = p;
    it.knot_value  = pick_word();
    it.slope_coef  = pick_word();
    it.curve_coef  = pick_word();
    it.cubic_coef  = pick_word();
    // Query fields are don't-care on a load but still toggle.
    it.query_pos   = $urandom;
    it.deriv_order = ORD_W'($urandom_range(7));
    planned_pos[e] = p;
    pending_items = {pending_items, it};
  endfunction

  function automatic void queue_query(logic signed [31:0] x, logic [ORD_W-1:0] ord);
    in_item_t it;
    it.action      = ACT_QUERY;
    it.entry_index = IDX_W'($urandom_range(63));
    it.knot_pos    = $urandom;
    it.knot_value  = $urandom;
    it.slope_coef  = $urandom;
    it.curve_coef  = $urandom;
    it.cubic_coef  = $urandom;
    it.query_pos   = x;
    it.deriv_order = ord;
    pending_items = {pending_items, it};
  endfunction

  // Loads all entries with increasing positions. A wide spacing spans the
  // whole 32-bit range; a narrow one keeps offsets near the fraction scale.
  function automatic void queue_table(int spacing);
    longint base;
    base = (spacing >= (1 << 26)) ? -64'sd2147483648
                                  : $signed(longint'($urandom_range(2000000))) - 1000000;
    for (int i = 0; i < MAX_KNOTS; i++) begin
      queue_load(i, 32'(base + longint'(i) * spacing + $urandom_range(spacing - 1)));
    end
  endfunction

  // Reloads one entry with a position kept strictly between its neighbors.
  function automatic void queue_sorted_reload();
    int     e;
    longint lo;
    longint hi;
    e  = $urandom_range(MAX_KNOTS - 1);
    lo = (e == 0) ? -64'sd2147483648 : longint'(planned_pos[e-1]) + 1;
    hi = (e == MAX_KNOTS - 1) ? 64'sd2147483647 : longint'(planned_pos[e+1]) - 1;
    if (lo <= hi) queue_load(e, 32'(lo + longint'({$urandom, $urandom} % (hi - lo + 1))));
  endfunction

  // Random query, aimed near a knot most of the time.
  function automatic void queue_random_query(int n);
    logic signed [31:0] x;
    int                 k;
    k = $urandom_range(n - 1);
    case ($urandom_range(5))
      0: x = $urandom;
      1: x = planned_pos[k];
      2: x = planned_pos[k] + 32'($signed($urandom_range(2047)) - 1024);
      3: x = ($urandom_range(1)) ? 32'h8000_0000 : 32'h7FFF_FFFF;
      default: x = planned_pos[k] + 32'($urandom_range(32'h0001_FFFF));
    endcase
    queue_query(x, ORD_W'(($urandom_range(9) < 8) ? $urandom_range(3) : $urandom_range(7)));
  endfunction

  // Waits until every queued item was taken and every result returned, then
  // lets the block finish any load still in flight.
  task automatic drain();
    do @(posedge clk_i); while (pending_items.size() > 0 || push || expected_results.size() > 0);
    repeat (60) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [DATA_W-1:0] data);
    @(posedge clk_i);
    valid       <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!ready);
    valid <= 1'b0;
    if (idx == CFG_KNOT_COUNT) knot_count_reg = data[KC_W-1:0];
    else left_curv_reg = data;
  endtask

  function automatic int clamped_count();
    return (knot_count_reg < 3) ? 3 : (knot_count_reg > MAX_KNOTS) ? MAX_KNOTS : knot_count_reg;
  endfunction

  // ---------------------------------------------------------------------
  // Test sequence.
  // ---------------------------------------------------------------------
  initial begin
    logic [KC_W-1:0]   counts[8];
    logic [DATA_W-1:0] curvs[8];
    int                n;
    counts = '{7'd3, 7'd64, 7'd0, 7'd2, 7'd127, 7'd65, 7'd17, 7'd40};
    curvs  = '{32'h0, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0001_0000,
               32'hFFFF_0000, 32'h0, 32'h0000_4000, 32'h8000_0000};

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed part: a table spanning the full range, queries at the
    // extremes, exactly on knots, and every order including unsupported ones.
    send_idle = 10;
    recv_idle = 68;
    queue_table(1 << 26);
    for (int o = 0; o < 8; o++) queue_query(32'h8000_0000, ORD_W'(o));
    for (int o = 0; o < 4; o++) queue_query(32'h7FFF_FFFF, ORD_W'(o));
    queue_query(planned_pos[0], ORD_VALUE);
    queue_query(planned_pos[2], ORD_FIRST);
    queue_query(planned_pos[1] + 1, ORD_THIRD);
    queue_query(planned_pos[1] - 1, ORD_SECOND);
    drain();

    // Register sweep. Each setting gets a fresh table and a random mix of
    // queries and in-order reloads; the last one scrambles the order.
    for (int ph = 0; ph < 8; ph++) begin
      if (ph < 3) begin
        send_idle = 10;
        recv_idle = 68;
      end else if (ph < 6) begin
        send_idle = 68;
        recv_idle = 10;
      end else begin
        send_idle = 0;
        recv_idle = 0;
      end
      write_reg(CFG_KNOT_COUNT, {25'($urandom_range(32'h01FF_FFFF)), counts[ph]});
      write_reg(CFG_LEFT_CURV, (ph == 6) ? pick_word() : curvs[ph]);
      n = clamped_count();
      queue_table((ph % 2) ? (1 << 26) : (1 << $urandom_range(10, 20)));
      if (ph == 7) begin
        // Unsorted table: several entries get arbitrary positions.
        for (int j = 0; j < 8; j++) queue_load($urandom_range(n - 1), $urandom);
      end
      for (int j = 0; j < 40; j++) begin
        if ($urandom_range(9) == 0) queue_sorted_reload();
        else queue_random_query(n);
      end
      drain();
    end

    if (errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Watchdog far beyond the slowest correct run.
  initial begin
    #20ms;
    $display("Mismatches found");
    $finish;
  end

endmodule

FILE: files.f
rtl/cse_pkg.sv
rtl/cse_ram.sv
rtl/cse_front.sv
rtl/cse_fifo.sv
rtl/cse_back.sv
rtl/cubic_spline_evaluator.sv
tb/cubic_spline_evaluator_tb.sv
